FILE: rtl/lpmd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the length-prefixed message deframer.
// No dependencies; imported by lpmd_parser and the top level.

package lpmd_pkg;

	localparam int HEADER_BYTES_DEF = 12;
	localparam int LEN_BYTES        = 4;
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1000;

	typedef enum logic {
		OP_DATA  = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_ERROR   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic       last;
	} result_t;

endpackage

FILE: rtl/lpmd_parser.sv
`timescale 1ns / 1ps
// Frame parser: header counter, length assembly and check, payload countdown.
// Depends on lpmd_pkg.

module lpmd_parser
	import lpmd_pkg::*;
#(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        op,
	input  logic [7:0]  data_byte,
	input  logic [15:0] max_payload,
	output logic        res_valid,
	output result_t     res
);

	localparam int CNT_W = $clog2(HEADER_BYTES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HEADER_BYTES - 1);

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [23:0]      shift_q, shift_d;
	logic [15:0]      left_q, left_d;
	logic [31:0]      len;
	logic             is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			count_q <= '0;
			shift_q <= '0;
			left_q  <= '0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			shift_q <= shift_d;
			left_q  <= left_d;
		end
	end

	// Only the newest three header bytes are kept; with the current byte they
	// form the big-endian length.
	assign len     = {shift_q, data_byte};
	assign is_last = (left_q <= 16'd1);

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		shift_d   = shift_q;
		left_d    = left_q;
		res_valid = 1'b0;
		res       = '{kind: KIND_BYTE, payload_byte: 8'd0, last: 1'b0};
		if (step) begin
			if (op == OP_CLEAR) begin
				phase_d = PH_HEADER;
				count_d = '0;
				shift_d = '0;
				left_d  = '0;
			end else begin
				unique case (phase_q)
					PH_ERROR: begin
						// drop bytes until a clear request
					end
					PH_PAYLOAD: begin
						res_valid = 1'b1;
						res       = '{kind: KIND_BYTE, payload_byte: data_byte, last: is_last};
						left_d    = left_q - 16'd1;
						if (is_last) begin
							phase_d = PH_HEADER;
							count_d = '0;
							shift_d = '0;
							left_d  = '0;
						end
					end
					default: begin
						if (count_q == CNT_LAST) begin
							count_d   = '0;
							shift_d   = '0;
							res_valid = 1'b1;
							if (len[31] || (|len[30:16]) || (len[15:0] > max_payload)) begin
								phase_d = PH_ERROR;
								left_d  = '0;
								res     = '{kind: KIND_ERROR, payload_byte: 8'd0, last: 1'b1};
							end else if (len[15:0] == 16'd0) begin
								phase_d = PH_HEADER;
								res     = '{kind: KIND_EMPTY, payload_byte: 8'd0, last: 1'b1};
							end else begin
								phase_d   = PH_PAYLOAD;
								left_d    = len[15:0];
								res_valid = 1'b0;
							end
						end else begin
							count_d = count_q + 1'b1;
							shift_d = len[23:0];
						end
					end
				endcase
			end
		end
	end

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> left_q != 16'd0)
		else $error("payload phase with zero bytes left");

	a_error_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR && op == OP_DATA |-> !res_valid)
		else $error("result produced in error state");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_LAST)
		else $error("header count out of range");

	a_error_enters: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_ERROR |=> phase_q == PH_ERROR)
		else $error("error result without error state");

endmodule

FILE: rtl/length_prefixed_message_deframer_unit.sv
`timescale 1ns / 1ps
// Top level of the length-prefixed message deframer.
// Depends on lpmd_pkg and lpmd_parser.
//
// Usage:
//   Input channel (in_valid / in_stall, op, data_byte) takes one stream byte
//   or a clear request per cycle unless stalled. A header of HEADER_BYTES
//   bytes ends in a big-endian signed 32-bit length; earlier ones are skipped.
//   Output channel (out_valid / out_stall, kind, payload_byte, last) gives one
//   result per payload byte, one empty-message result for length zero, or one
//   error result for a negative or oversize length, after which data bytes
//   are dropped until a clear request.
//   Config channel (cfg_valid / cfg_ready, cfg_data) writes max_payload;
//   cfg_ready is always high. Write it only while the block is idle.
// Timing:
//   A request is registered in the input register at its accept edge, and
//   its result, if any, is registered in the result register, which drives
//   out_valid. One request per cycle is sustained while no result is held
//   by out_stall; the input register and the result register advance together
//   whenever the result register is empty or being taken.
// Reset and stall:
//   Reset empties both registers, returns to the header phase and sets
//   max_payload to 1000. While out_stall holds a waiting result, in_stall
//   rises once the input register is also full.

module length_prefixed_message_deframer_unit
	import lpmd_pkg::*;
#(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	result_t     res_q;
	logic [15:0] max_payload_q;
	logic        advance;
	logic        res_valid;
	result_t     res;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_payload_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			op_s1   <= op;
			byte_s1 <= data_byte;
		end
	end

	lpmd_parser #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (valid_s1 && advance),
		.op         (op_s1),
		.data_byte  (byte_s1),
		.max_payload(max_payload_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = res_q.kind;
	assign payload_byte = res_q.payload_byte;
	assign last         = res_q.last;

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall && valid_s1 |-> in_stall)
		else $error("input taken while both registers are full");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(res_q))
		else $error("held result changed under stall");

	a_free_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> !in_stall)
		else $error("stall raised with empty result register");

endmodule
